/* src/btp_pkg.sv */
// shared constants for the blended trajectory table player
package btp_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int JOINT_COUNT = 7;
    localparam int VALUE_WIDTH = 32;
    localparam int TIME_WIDTH  = 48;

    localparam int SLOT_W  = 10;
    localparam int JOINT_W = 3;
    localparam int PER_W   = 32;
    localparam int NSMP_W  = 11;
    localparam int BLEND_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int HALF_DEPTH  = MAX_SAMPLES * JOINT_COUNT;
    localparam int STORE_DEPTH = 2 * HALF_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PROD_W      = PER_W + SLOT_W;
    localparam int CNT_W       = $clog2(TIME_WIDTH + 1);
    localparam int MUL_W       = VALUE_WIDTH + 1 + BLEND_W + 1;
    localparam int BLEND_ONE   = 65536;
    localparam int FRAC_BITS   = 16;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND   = 2'd2;

    localparam int TRJ_LSB   = 0;
    localparam int SLOT_LSB  = TRJ_LSB + 1;
    localparam int JOINT_LSB = SLOT_LSB + SLOT_W;
    localparam int POS_LSB   = JOINT_LSB + JOINT_W;
    localparam int VEL_LSB   = POS_LSB + VALUE_WIDTH;
    localparam int TIME_LSB  = VEL_LSB + VALUE_WIDTH;
    localparam int IN_BITS   = TIME_LSB + TIME_WIDTH;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS   = JOINT_W + 2 * VALUE_WIDTH;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

/* src/blended_trajectory_table_player_top.sv */
// blended trajectory table player: two joint trajectory tables, indexed by time, blended
//
// channel  direction  handshake                       payload
// s_axis   in         i_s_axis_tvalid/o_s_axis_tready tuser op, tdata write fields or time
// m_axis   out        o_m_axis_tvalid/i_m_axis_tready tdata joint result, tlast last joint
// cfg      in         i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// a table write or a rejected sample leaves the input ready; a restart plays sample 0 from the base state
// a sample word passes twice through the shared one-bit-per-cycle divider (ticks, then the
// scaled remainder) with one multiply between, then a base step, then per joint a memory
// read, a blend multiply and an emit; the input is ready again after the last joint's emit
// reset clears control and config registers only; table contents are undefined until written
// the input is stalled while a word is in flight; a stalled output stalls the joint sequence
module blended_trajectory_table_player_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // trajectory, slot, joint, position, velocity, elapsed ticks
    input  logic [btp_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // operation
    input  logic [btp_pkg::OP_W-1:0]           i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // joint index, joint position, joint velocity
    output logic [btp_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [btp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [btp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import btp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_BASE = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_CALC = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    localparam logic [ADDR_W-1:0]  HALF_ADDR   = ADDR_W'(HALF_DEPTH);
    localparam logic [ADDR_W-1:0]  JOINTS_ADDR = ADDR_W'(JOINT_COUNT);
    localparam logic [JOINT_W-1:0] LAST_JOINT  = JOINT_W'(JOINT_COUNT - 1);
    localparam logic [SLOT_W:0]    SLOT_LIMIT  = (SLOT_W + 1)'(MAX_SAMPLES);
    localparam logic [NSMP_W-1:0]  NSMP_MIN    = NSMP_W'(2);
    localparam logic [NSMP_W-1:0]  NSMP_MAX    = NSMP_W'(MAX_SAMPLES);
    localparam logic [BLEND_W-1:0] F_ONE       = BLEND_W'(BLEND_ONE);

    // config registers
    logic [PER_W-1:0]   r_period;
    logic [NSMP_W-1:0]  r_samples;
    logic [BLEND_W-1:0] r_blend;

    // control
    logic [2:0]            r_state;
    logic [TIME_WIDTH-1:0] r_prev_time;
    logic                  r_first;
    logic                  r_phase;
    logic [CNT_W-1:0]      r_cnt;
    logic [PER_W-1:0]      r_rem;
    logic [TIME_WIDTH-1:0] r_dvd;
    logic [ADDR_W-1:0]     r_addr;
    logic [JOINT_W-1:0]    r_joint;

    // tables and datapath
    logic [VALUE_WIDTH-1:0] r_pos_mem [STORE_DEPTH];
    logic [VALUE_WIDTH-1:0] r_vel_mem [STORE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_pa, r_pb, r_va, r_vb;
    logic signed [MUL_W-1:0]       r_pp, r_vp;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    // input fields
    logic [OP_W-1:0]        in_op;
    logic                   in_trj;
    logic [SLOT_W-1:0]      in_slot;
    logic [JOINT_W-1:0]     in_joint;
    logic [VALUE_WIDTH-1:0] in_pos, in_vel;
    logic [TIME_WIDTH-1:0]  in_time;
    logic                   in_acc;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;

    assign in_op    = i_s_axis_tuser;
    assign in_trj   = i_s_axis_tdata[TRJ_LSB];
    assign in_slot  = i_s_axis_tdata[SLOT_LSB +: SLOT_W];
    assign in_joint = i_s_axis_tdata[JOINT_LSB +: JOINT_W];
    assign in_pos   = i_s_axis_tdata[POS_LSB +: VALUE_WIDTH];
    assign in_vel   = i_s_axis_tdata[VEL_LSB +: VALUE_WIDTH];
    assign in_time  = i_s_axis_tdata[TIME_LSB +: TIME_WIDTH];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign wr_en = in_acc && (in_op == OP_WRITE) && ({1'b0, in_slot} < SLOT_LIMIT)
                   && (in_joint < JOINT_W'(JOINT_COUNT));
    assign wr_addr = ADDR_W'(in_slot) * JOINTS_ADDR + ADDR_W'(in_joint)
                     + (in_trj ? HALF_ADDR : '0);

    // effective config
    logic [PER_W-1:0]   per_eff;
    logic [NSMP_W-1:0]  nsmp_eff;
    logic [SLOT_W-1:0]  nm1;
    logic [BLEND_W-1:0] f_eff;

    assign per_eff = (r_period == '0) ? PER_W'(1) : r_period;
    always_comb begin
        if (r_samples < NSMP_MIN) begin
            nsmp_eff = NSMP_MIN;
        end else if (r_samples > NSMP_MAX) begin
            nsmp_eff = NSMP_MAX;
        end else begin
            nsmp_eff = r_samples;
        end
    end
    assign nm1   = SLOT_W'(nsmp_eff - NSMP_W'(1));
    assign f_eff = (r_blend > F_ONE) ? F_ONE : r_blend;

    // one restoring divide step
    logic [PER_W:0]   trial;
    logic [PER_W:0]   trial_sub;
    logic             q_bit;
    logic [PROD_W-1:0] prod;

    assign trial     = {r_rem, r_dvd[TIME_WIDTH-1]};
    assign trial_sub = trial - {1'b0, per_eff};
    assign q_bit     = (trial >= {1'b0, per_eff});
    assign prod      = PROD_W'(r_rem) * PROD_W'(nm1);

    // blend datapath
    logic signed [VALUE_WIDTH:0] pdiff, vdiff;
    logic signed [BLEND_W:0]     f_s;
    logic [VALUE_WIDTH-1:0]      pos_sum, vel_sum;

    assign pdiff   = {r_pb[VALUE_WIDTH-1], r_pb} - {r_pa[VALUE_WIDTH-1], r_pa};
    assign vdiff   = {r_vb[VALUE_WIDTH-1], r_vb} - {r_va[VALUE_WIDTH-1], r_va};
    assign f_s     = $signed({1'b0, f_eff});
    assign pos_sum = r_pa + r_pp[FRAC_BITS +: VALUE_WIDTH];
    assign vel_sum = r_va + r_vp[FRAC_BITS +: VALUE_WIDTH];

    logic out_free;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PER_W'(1000);
            r_samples <= NSMP_MAX;
            r_blend   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PERIOD:  r_period  <= i_cfg_data[PER_W-1:0];
                CFG_SAMPLES: r_samples <= i_cfg_data[NSMP_W-1:0];
                CFG_BLEND:   r_blend   <= i_cfg_data[BLEND_W-1:0];
                default: ;
            endcase
        end
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pos_mem[wr_addr] <= in_pos;
        end
        if (r_state == S_READ) begin
            r_pa <= r_pos_mem[r_addr];
            r_pb <= r_pos_mem[r_addr + HALF_ADDR];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_vel_mem[wr_addr] <= in_vel;
        end
        if (r_state == S_READ) begin
            r_va <= r_vel_mem[r_addr];
            r_vb <= r_vel_mem[r_addr + HALF_ADDR];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_pp <= MUL_W'(pdiff) * MUL_W'(f_s);
            r_vp <= MUL_W'(vdiff) * MUL_W'(f_s);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_time <= '0;
            r_first     <= 1'b1;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            r_joint     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (in_op == OP_SAMPLE)
                        && ((in_time > r_prev_time) || r_first)) begin
                        r_prev_time <= in_time;
                        r_first     <= 1'b0;
                        r_rem       <= '0;
                        r_dvd       <= in_time;
                        r_cnt       <= CNT_W'(TIME_WIDTH);
                        r_phase     <= 1'b0;
                        r_state     <= S_DIV;
                    end else if (in_acc && (in_op == OP_RESTART)) begin
                        r_prev_time <= '0;
                        r_first     <= 1'b0;
                        r_dvd       <= '0;
                        r_state     <= S_BASE;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? trial_sub[PER_W-1:0] : trial[PER_W-1:0];
                    r_dvd <= {r_dvd[TIME_WIDTH-2:0], q_bit};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= r_phase ? S_BASE : S_MUL;
                    end
                end
                S_MUL: begin
                    r_rem   <= prod[PROD_W-1:SLOT_W];
                    r_dvd   <= {prod[SLOT_W-1:0], (TIME_WIDTH - SLOT_W)'(0)};
                    r_cnt   <= CNT_W'(SLOT_W);
                    r_phase <= 1'b1;
                    r_state <= S_DIV;
                end
                S_BASE: begin
                    r_addr  <= ADDR_W'(r_dvd[SLOT_W-1:0]) * JOINTS_ADDR;
                    r_joint <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_joint == LAST_JOINT) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_joint <= r_joint + JOINT_W'(1);
                            r_addr  <= r_addr + ADDR_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_data <= OUT_DATA_W'({vel_sum, pos_sum, r_joint});
            r_out_last <= (r_joint == LAST_JOINT);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // a run keeps going after a result that is not the last joint
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast)
        |=> ((r_state != S_IDLE) || (o_m_axis_tvalid && o_m_axis_tlast)))
        else $error("run ended before last joint");

    // the table read base address stays inside the first trajectory half
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_addr < HALF_ADDR))
        else $error("table read address out of range");

    // divider partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < per_eff))
        else $error("divider remainder not below period");
`endif

endmodule

/* verif/joint_result_checker.sv */
`timescale 1ns / 1ps
// checker for the blended trajectory table player: predicts joint results and compares them
module joint_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               i_s_axis_tready,
    input  logic [btp_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic [btp_pkg::OP_W-1:0]           i_s_axis_tuser,
    input  logic                               i_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [btp_pkg::OUT_DATA_W-1:0]     i_m_axis_tdata,
    input  logic                               i_m_axis_tlast,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [btp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [btp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import btp_pkg::*;

    typedef struct packed {
        logic [JOINT_W-1:0]     joint;
        logic [VALUE_WIDTH-1:0] position;
        logic [VALUE_WIDTH-1:0] velocity;
        logic                   last;
    } joint_result_t;

    joint_result_t           joint_results_due[$];
    logic [VALUE_WIDTH-1:0]  position_table [STORE_DEPTH];
    logic [VALUE_WIDTH-1:0]  velocity_table [STORE_DEPTH];
    logic [TIME_WIDTH-1:0]   prev_ticks;
    logic                    first_open;
    logic [PER_W-1:0]        period_reg;
    logic [NSMP_W-1:0]       samples_reg;
    logic [BLEND_W-1:0]      blend_reg;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [VALUE_WIDTH-1:0] blend_word(logic signed [VALUE_WIDTH-1:0] a,
                                                          logic signed [VALUE_WIDTH-1:0] b,
                                                          logic [BLEND_W-1:0] f);
        longint diff;
        longint weight;
        longint sum;
        weight = f;
        diff   = longint'(b) - longint'(a);
        sum    = longint'(a) + ((diff * weight) >>> FRAC_BITS);
        return sum[VALUE_WIDTH-1:0];
    endfunction

    function automatic void queue_joint_results(logic [TIME_WIDTH-1:0] ticks);
        logic [63:0]          per;
        logic [63:0]          n;
        logic [63:0]          t;
        logic [63:0]          slot;
        logic [BLEND_W-1:0]   f;
        int                   first_entry;
        joint_result_t        r;
        per = (period_reg == 0) ? 64'd1 : period_reg;
        n   = samples_reg;
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_SAMPLES) begin
            n = MAX_SAMPLES;
        end
        f    = (blend_reg > BLEND_ONE) ? BLEND_W'(BLEND_ONE) : blend_reg;
        t    = ticks;
        slot = ((t % per) * (n - 1)) / per;
        if (slot >= MAX_SAMPLES) begin
            slot = MAX_SAMPLES - 1;
        end
        for (int j = 0; j < JOINT_COUNT; j++) begin
            first_entry = int'(slot) * JOINT_COUNT + j;
            r.joint    = JOINT_W'(j);
            r.position = blend_word(position_table[first_entry],
                                    position_table[first_entry + HALF_DEPTH], f);
            r.velocity = blend_word(velocity_table[first_entry],
                                    velocity_table[first_entry + HALF_DEPTH], f);
            r.last     = (j == JOINT_COUNT - 1);
            joint_results_due = {joint_results_due, r};
        end
    endfunction

    always @(posedge i_clk) begin
        joint_result_t          got;
        joint_result_t          want;
        logic [TIME_WIDTH-1:0]  ticks;
        logic [JOINT_W-1:0]     joint;
        logic [SLOT_W-1:0]      slot;
        int                     entry;
        if (!i_rst_n) begin
            joint_results_due.delete();
            period_reg  <= PER_W'(1000);
            samples_reg <= NSMP_W'(1024);
            blend_reg   <= '0;
            prev_ticks  <= '0;
            first_open  <= 1'b1;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.joint    = i_m_axis_tdata[JOINT_W-1:0];
                got.position = i_m_axis_tdata[JOINT_W +: VALUE_WIDTH];
                got.velocity = i_m_axis_tdata[JOINT_W + VALUE_WIDTH +: VALUE_WIDTH];
                got.last     = i_m_axis_tlast;
                if (joint_results_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected word: joint %0d pos %h vel %h last %0d",
                                 $realtime, got.joint, got.position, got.velocity, got.last);
                    end
                end else begin
                    want = joint_results_due.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch: expected joint %0d pos %h vel %h last %0d",
                                     $realtime, want.joint, want.position, want.velocity,
                                     want.last);
                            $display("%0t:           actual   joint %0d pos %h vel %h last %0d",
                                     $realtime, got.joint, got.position, got.velocity,
                                     got.last);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PERIOD:  period_reg  <= i_cfg_data[PER_W-1:0];
                    CFG_SAMPLES: samples_reg <= i_cfg_data[NSMP_W-1:0];
                    CFG_BLEND:   blend_reg   <= i_cfg_data[BLEND_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                ticks = i_s_axis_tdata[TIME_LSB +: TIME_WIDTH];
                joint = i_s_axis_tdata[JOINT_LSB +: JOINT_W];
                slot  = i_s_axis_tdata[SLOT_LSB +: SLOT_W];
                case (i_s_axis_tuser)
                    OP_WRITE: begin
                        if (joint < JOINT_COUNT) begin
                            entry = (int'(i_s_axis_tdata[TRJ_LSB]) * MAX_SAMPLES + int'(slot))
                                    * JOINT_COUNT + int'(joint);
                            position_table[entry] = i_s_axis_tdata[POS_LSB +: VALUE_WIDTH];
                            velocity_table[entry] = i_s_axis_tdata[VEL_LSB +: VALUE_WIDTH];
                        end
                    end
                    OP_SAMPLE: begin
                        if (ticks > prev_ticks || first_open) begin
                            prev_ticks <= ticks;
                            first_open <= 1'b0;
                            queue_joint_results(ticks);
                        end
                    end
                    OP_RESTART: begin
                        prev_ticks <= '0;
                        first_open <= 1'b0;
                        queue_joint_results('0);
                    end
                    default: ;
                endcase
            end
        end
        o_pending = joint_results_due.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench top for the blended trajectory table player: stimulus, handshakes and verdict
module tb;
    import btp_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          PHASE_WORDS   = 65;
    localparam logic [63:0] TIME_MAX      = (64'd1 << TIME_WIDTH) - 1;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_valid;
    logic                   s_ready;
    logic [IN_DATA_W-1:0]   s_data;
    logic [OP_W-1:0]        s_user;
    logic                   m_valid;
    logic                   m_ready;
    logic [OUT_DATA_W-1:0]  m_data;
    logic                   m_last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;
    int                     cycle_count;
    int                     sent_words;
    logic                   calm;

    logic [PER_W-1:0]       period_cfg;
    logic [NSMP_W-1:0]      samples_cfg;
    logic [63:0]            now_ticks;
    bit                     slot_loaded [MAX_SAMPLES];

    blended_trajectory_table_player_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    joint_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_ready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] rand_value();
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int slot_for(logic [TIME_WIDTH-1:0] ticks);
        logic [63:0] per;
        logic [63:0] n;
        logic [63:0] t;
        per = (period_cfg == 0) ? 64'd1 : period_cfg;
        n   = samples_cfg;
        t   = ticks;
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_SAMPLES) begin
            n = MAX_SAMPLES;
        end
        return int'(((t % per) * (n - 1)) / per);
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic trj, logic [SLOT_W-1:0] slot,
                             logic [JOINT_W-1:0] joint, logic [VALUE_WIDTH-1:0] pos,
                             logic [VALUE_WIDTH-1:0] vel, logic [TIME_WIDTH-1:0] ticks);
        logic [IN_DATA_W-1:0] word;
        word                            = '0;
        word[TRJ_LSB]                   = trj;
        word[SLOT_LSB +: SLOT_W]        = slot;
        word[JOINT_LSB +: JOINT_W]      = joint;
        word[POS_LSB +: VALUE_WIDTH]    = pos;
        word[VEL_LSB +: VALUE_WIDTH]    = vel;
        word[TIME_LSB +: TIME_WIDTH]    = ticks;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
        sent_words++;
    endtask

    task automatic send_control(logic [OP_W-1:0] op, logic [TIME_WIDTH-1:0] ticks);
        send_word(op, 1'($urandom), SLOT_W'($urandom), JOINT_W'($urandom), rand_value(),
                  rand_value(), ticks);
    endtask

    task automatic load_slot(int slot);
        for (int trj = 0; trj < 2; trj++) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                send_word(OP_WRITE, 1'(trj), SLOT_W'(slot), JOINT_W'(j), rand_value(),
                          rand_value(), TIME_WIDTH'(rand64()));
            end
        end
        slot_loaded[slot] = 1'b1;
    endtask

    task automatic sample_at(logic [TIME_WIDTH-1:0] ticks);
        int slot;
        slot = slot_for(ticks);
        if (!slot_loaded[slot]) begin
            load_slot(slot);
        end
        send_control(OP_SAMPLE, ticks);
    endtask

    task automatic restart_play();
        send_control(OP_RESTART, TIME_WIDTH'(rand64()));
        now_ticks = 0;
    endtask

    task automatic advance_and_sample();
        logic [63:0] per;
        logic [63:0] step;
        logic [63:0] target;
        per = (period_cfg == 0) ? 64'd1 : period_cfg;
        case ($urandom_range(7))
            0:       step = 1;
            1, 2:    step = 1 + rand64() % per;
            3, 4:    step = 1 + rand64() % (4 * per);
            5, 6:    step = 1 + $urandom_range(5000);
            default: step = 1 + rand64() % (TIME_MAX - now_ticks + 1);
        endcase
        target = now_ticks + step;
        if (target > TIME_MAX) begin
            restart_play();
        end else begin
            now_ticks = target;
            sample_at(target[TIME_WIDTH-1:0]);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (index)
            CFG_PERIOD:  period_cfg  = value[PER_W-1:0];
            CFG_SAMPLES: samples_cfg = value[NSMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic random_words(int count);
        int stop;
        int pick;
        stop = sent_words + count;
        while (sent_words < stop) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_word(OP_WRITE, 1'($urandom), SLOT_W'($urandom), JOINT_W'($urandom),
                          rand_value(), rand_value(), TIME_WIDTH'(rand64()));
            end else if (pick < 80) begin
                advance_and_sample();
            end else if (pick < 88) begin
                sample_at(TIME_WIDTH'(rand64() % (now_ticks + 1)));
            end else if (pick < 95) begin
                restart_play();
            end else begin
                send_control(OP_UNKNOWN, TIME_WIDTH'(rand64()));
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] period_set [6];
        logic [CFG_DATA_W-1:0] samples_set [6];
        logic [CFG_DATA_W-1:0] blend_set [6];
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        s_user      = OP_WRITE;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_PERIOD;
        cfg_data    = '0;
        cycle_count = 0;
        sent_words  = 0;
        calm        = 1'b0;
        period_cfg  = PER_W'(1000);
        samples_cfg = NSMP_W'(1024);
        now_ticks   = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // extreme values in slot 0, opposite signs in the two trajectories
        for (int j = 0; j < JOINT_COUNT; j++) begin
            send_word(OP_WRITE, 1'b0, '0, JOINT_W'(j), 32'h8000_0000, 32'h7FFF_FFFF,
                      TIME_WIDTH'(rand64()));
            send_word(OP_WRITE, 1'b1, '0, JOINT_W'(j), 32'h7FFF_FFFF, 32'h8000_0000,
                      TIME_WIDTH'(rand64()));
        end
        slot_loaded[0] = 1'b1;
        sample_at('0);
        sample_at('0);
        send_word(OP_WRITE, 1'b1, '1, 3'd7, '1, '1, '1);
        send_control(OP_UNKNOWN, '1);
        sample_at(TIME_WIDTH'(999));
        sample_at(TIME_WIDTH'(1000));
        sample_at(TIME_WIDTH'(500));
        restart_play();
        sample_at('0);
        sample_at(TIME_MAX[TIME_WIDTH-1:0]);
        restart_play();

        period_set  = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(5000, 2)), 32'd37,
                        32'd1000};
        samples_set = '{32'd2, 32'd0, 32'd1024, 32'($urandom_range(1024, 2)), 32'h7FF, 32'd1};
        blend_set   = '{32'd65536, 32'h1_FFFF, 32'd32768, 32'($urandom_range(65536)), 32'd1,
                        32'd0};
        for (int p = 0; p < 6; p++) begin
            settle();
            write_reg(CFG_PERIOD, period_set[p]);
            write_reg(CFG_SAMPLES, {$urandom} << NSMP_W | samples_set[p]);
            write_reg(CFG_BLEND, {$urandom} << BLEND_W | blend_set[p]);
            calm = (p == 2);
            random_words(PHASE_WORDS);
        end
        calm = 1'b0;
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
